[design/per_channel_median_abs_deviation_top_assert.svh]
// ---------------------------------------------------------------------------
// MAD assertion macros
// Clocked assertion helpers used by the MAD datapath.
// ---------------------------------------------------------------------------
`ifndef PER_CHANNEL_MEDIAN_ABS_DEVIATION_TOP_ASSERT_SVH
`define PER_CHANNEL_MEDIAN_ABS_DEVIATION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MAD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("MAD assertion failed");
`define MAD_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("MAD forbidden condition seen");
`else
`define MAD_ASSERT(lbl, clk, rst_n, prop)
`define MAD_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[design/pcmad_pkg.sv]
// ---------------------------------------------------------------------------
// MAD package
// Types and fixed constants shared by the MAD block.
// ---------------------------------------------------------------------------
package pcmad_pkg;

  localparam int SAMPLE_W = 17;
  localparam int CH_W     = 2;
  localparam int CFG_W    = 3;
  localparam int BIT_W    = 5;
  localparam logic [BIT_W-1:0] TOP_BIT = 5'd16;
  localparam logic [SAMPLE_W-1:0] Q_ONE = 17'd65536;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CH_START,
    ST_SCAN,
    ST_STEP,
    ST_EMIT,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic load;       // take input items
    logic ch_start;   // open a channel, start its first scan if it holds samples
    logic step;       // settle one answer bit
    logic emit;       // load the result register
    logic next_ch;    // move to the next channel
    logic clear_run;  // drop counts and flags after the run
  } cmd_t;

  typedef struct packed {
    logic last_fire;  // final input item accepted
    logic ch_empty;   // current channel holds no samples
    logic scan_done;  // pass over the store finished
    logic bit_zero;   // working on the last answer bit
    logic dev_mode;   // working on the deviations
    logic out_taken;  // result item accepted
    logic last_ch;    // current channel is the last one
  } sts_t;

endpackage

[design/pcmad_if.sv]
// ---------------------------------------------------------------------------
// MAD channel interfaces
// Valid/ready channels for samples, results and configuration.
// ---------------------------------------------------------------------------
interface pcmad_in_if;
  logic                              valid;
  logic                              ready;
  logic [pcmad_pkg::CH_W-1:0]        channel;
  logic [pcmad_pkg::SAMPLE_W-1:0]    sample;
  logic                              sample_last;
  modport source (output valid, channel, sample, sample_last, input ready);
  modport sink (input valid, channel, sample, sample_last, output ready);
endinterface

interface pcmad_out_if;
  logic                              valid;
  logic                              ready;
  logic [pcmad_pkg::CH_W-1:0]        out_channel;
  logic [pcmad_pkg::SAMPLE_W-1:0]    mad;
  logic                              overflowed;
  logic                              result_last;
  modport source (output valid, out_channel, mad, overflowed, result_last, input ready);
  modport sink (input valid, out_channel, mad, overflowed, result_last, output ready);
endinterface

interface pcmad_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pcmad_pkg::CFG_W-1:0]       data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[design/pcmad_ctrl.sv]
// ---------------------------------------------------------------------------
// MAD controller
// Sequences loading, the bitwise selection passes and result delivery.
// ---------------------------------------------------------------------------
module pcmad_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  pcmad_pkg::sts_t  sts,
  output pcmad_pkg::cmd_t  cmd
);

  pcmad_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcmad_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcmad_pkg::ST_LOAD: begin
        if (sts.last_fire) state_nxt = pcmad_pkg::ST_CH_START;
      end
      pcmad_pkg::ST_CH_START: begin
        state_nxt = sts.ch_empty ? pcmad_pkg::ST_EMIT : pcmad_pkg::ST_SCAN;
      end
      pcmad_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = pcmad_pkg::ST_STEP;
      end
      pcmad_pkg::ST_STEP: begin
        if (sts.bit_zero && sts.dev_mode) state_nxt = pcmad_pkg::ST_EMIT;
        else state_nxt = pcmad_pkg::ST_SCAN;
      end
      pcmad_pkg::ST_EMIT: begin
        state_nxt = pcmad_pkg::ST_WAIT;
      end
      pcmad_pkg::ST_WAIT: begin
        if (sts.out_taken) begin
          state_nxt = sts.last_ch ? pcmad_pkg::ST_LOAD : pcmad_pkg::ST_CH_START;
        end
      end
      default: state_nxt = pcmad_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      pcmad_pkg::ST_LOAD:     cmd.load = 1'b1;
      pcmad_pkg::ST_CH_START: cmd.ch_start = 1'b1;
      pcmad_pkg::ST_SCAN:     cmd = '0;
      pcmad_pkg::ST_STEP:     cmd.step = 1'b1;
      pcmad_pkg::ST_EMIT:     cmd.emit = 1'b1;
      pcmad_pkg::ST_WAIT: begin
        cmd.next_ch   = sts.out_taken && !sts.last_ch;
        cmd.clear_run = sts.out_taken && sts.last_ch;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[design/pcmad_dp.sv]
// ---------------------------------------------------------------------------
// MAD datapath
// Sample store, per-channel counts and the bitwise order-statistic unit.
// ---------------------------------------------------------------------------
`include "per_channel_median_abs_deviation_top_assert.svh"

module pcmad_dp #(
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_SAMPLES  = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pcmad_pkg::cmd_t  cmd,
  output pcmad_pkg::sts_t  sts,
  pcmad_in_if.sink         in_bus,
  pcmad_out_if.source      out_bus,
  pcmad_cfg_if.sink        cfg_bus
);

  localparam int SW  = pcmad_pkg::SAMPLE_W;
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int IW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NW  = $clog2(MAX_CHANNELS + 1);
  localparam int DEPTH = MAX_CHANNELS * MAX_SAMPLES;
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SW-1:0]    mem [DEPTH];
  logic [CW-1:0]    cnt_r [MAX_CHANNELS];
  logic             ovf_r [MAX_CHANNELS];
  logic [pcmad_pkg::CFG_W-1:0] cfg_r;
  logic [CHW-1:0]   cur_ch_r;
  logic [IW-1:0]    idx_r;
  logic             issuing_r, rd_vld_r, dev_mode_r;
  logic [SW-1:0]    rd_data_r, med_r, lo_ans_r, hi_ans_r;
  logic [CW-1:0]    lo_cnt_r, hi_cnt_r;
  logic [pcmad_pkg::BIT_W-1:0] bit_r;
  logic             out_valid_r;
  logic [pcmad_pkg::CH_W-1:0] out_ch_r;
  logic [SW-1:0]    out_mad_r;
  logic             out_ovf_r, out_last_r;

  logic [NW-1:0]    nch;
  logic [CHW-1:0]   in_ch;
  logic             in_fire, in_use, wr_en;
  logic [SW-1:0]    in_val, v, lo_try, hi_try, lo_new, hi_new;
  logic [CW-1:0]    n_cur, k_lo, k_hi;
  logic [SW:0]      ans_sum, med_sum;
  logic             scan_init, last_item;

  // Effective channel count: zero acts as one, large values clip.
  always_comb begin
    if (cfg_r == '0) nch = NW'(1);
    else if (int'(cfg_r) > MAX_CHANNELS) nch = NW'(MAX_CHANNELS);
    else nch = NW'(cfg_r);
  end

  assign in_fire = in_bus.valid && in_bus.ready;
  assign in_ch   = CHW'(in_bus.channel);
  assign in_use  = int'(in_bus.channel) < int'(nch);
  assign in_val  = (in_bus.sample > pcmad_pkg::Q_ONE) ? pcmad_pkg::Q_ONE : in_bus.sample;
  assign wr_en   = in_fire && in_use && (int'(cnt_r[in_ch]) < MAX_SAMPLES);

  assign n_cur = cnt_r[cur_ch_r];
  assign k_lo  = (n_cur - CW'(1)) >> 1;
  assign k_hi  = n_cur >> 1;
  assign last_item = (CW'(idx_r) + CW'(1)) == n_cur;

  assign lo_try = lo_ans_r | (SW'(1) << bit_r);
  assign hi_try = hi_ans_r | (SW'(1) << bit_r);
  assign lo_new = (lo_cnt_r <= k_lo) ? lo_try : lo_ans_r;
  assign hi_new = (hi_cnt_r <= k_hi) ? hi_try : hi_ans_r;
  assign med_sum = {1'b0, lo_new} + {1'b0, hi_new};
  assign ans_sum = {1'b0, lo_ans_r} + {1'b0, hi_ans_r};

  always_comb begin
    if (!dev_mode_r) v = rd_data_r;
    else if (rd_data_r >= med_r) v = rd_data_r - med_r;
    else v = med_r - rd_data_r;
  end

  assign scan_init = (cmd.ch_start && (n_cur != '0)) ||
                     (cmd.step && !(bit_r == '0 && dev_mode_r));

  // Store: one write port while loading, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(in_ch) * AW'(MAX_SAMPLES) + AW'(cnt_r[in_ch])] <= in_val;
    end
    if (issuing_r) begin
      rd_data_r <= mem[AW'(cur_ch_r) * AW'(MAX_SAMPLES) + AW'(idx_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        cnt_r[c] <= '0;
        ovf_r[c] <= 1'b0;
      end
      cfg_r       <= pcmad_pkg::CFG_W'(4);
      cur_ch_r    <= '0;
      issuing_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      dev_mode_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) cfg_r <= cfg_bus.data;
      if (wr_en) cnt_r[in_ch] <= cnt_r[in_ch] + CW'(1);
      if (in_fire && in_use && !wr_en) ovf_r[in_ch] <= 1'b1;
      if (in_fire && in_bus.sample_last) cur_ch_r <= '0;
      if (cmd.next_ch) cur_ch_r <= cur_ch_r + CHW'(1);
      if (cmd.clear_run) begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          cnt_r[c] <= '0;
          ovf_r[c] <= 1'b0;
        end
      end
      rd_vld_r <= issuing_r;
      if (scan_init) issuing_r <= 1'b1;
      else if (issuing_r && last_item) issuing_r <= 1'b0;
      if (cmd.ch_start) dev_mode_r <= 1'b0;
      else if (cmd.step && bit_r == '0) dev_mode_r <= 1'b1;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_bus.valid && out_bus.ready) out_valid_r <= 1'b0;
    end
  end

  // Bitwise selection: an answer bit is kept when few enough values lie below it.
  always_ff @(posedge clk) begin
    if (scan_init) begin
      idx_r    <= '0;
      lo_cnt_r <= '0;
      hi_cnt_r <= '0;
    end else begin
      if (issuing_r) idx_r <= idx_r + IW'(1);
      if (rd_vld_r && v < lo_try) lo_cnt_r <= lo_cnt_r + CW'(1);
      if (rd_vld_r && v < hi_try) hi_cnt_r <= hi_cnt_r + CW'(1);
    end
    if (cmd.ch_start) begin
      bit_r    <= pcmad_pkg::TOP_BIT;
      lo_ans_r <= '0;
      hi_ans_r <= '0;
    end else if (cmd.step) begin
      if (bit_r != '0) begin
        bit_r    <= bit_r - pcmad_pkg::BIT_W'(1);
        lo_ans_r <= lo_new;
        hi_ans_r <= hi_new;
      end else if (!dev_mode_r) begin
        med_r    <= med_sum[SW:1];
        bit_r    <= pcmad_pkg::TOP_BIT;
        lo_ans_r <= '0;
        hi_ans_r <= '0;
      end else begin
        lo_ans_r <= lo_new;
        hi_ans_r <= hi_new;
      end
    end
    if (cmd.emit) begin
      out_ch_r   <= pcmad_pkg::CH_W'(cur_ch_r);
      out_mad_r  <= ans_sum[SW:1];
      out_ovf_r  <= ovf_r[cur_ch_r];
      out_last_r <= (NW'(cur_ch_r) + NW'(1)) == nch;
    end
  end

  assign in_bus.ready  = cmd.load;
  assign cfg_bus.ready = 1'b1;
  assign out_bus.valid       = out_valid_r;
  assign out_bus.out_channel = out_ch_r;
  assign out_bus.mad         = out_mad_r;
  assign out_bus.overflowed  = out_ovf_r;
  assign out_bus.result_last = out_last_r;

  assign sts.last_fire = in_fire && in_bus.sample_last;
  assign sts.ch_empty  = n_cur == '0;
  assign sts.scan_done = !issuing_r && !rd_vld_r;
  assign sts.bit_zero  = bit_r == '0;
  assign sts.dev_mode  = dev_mode_r;
  assign sts.out_taken = out_valid_r && out_bus.ready;
  assign sts.last_ch   = (NW'(cur_ch_r) + NW'(1)) == nch;

  `MAD_NEVER(a_no_scan_while_out, clk, rst_n, issuing_r && out_valid_r)
  `MAD_ASSERT(a_rd_follows_issue, clk, rst_n, rd_vld_r |-> $past(issuing_r))
  `MAD_NEVER(a_no_load_during_scan, clk, rst_n, in_bus.ready && (issuing_r || rd_vld_r))

endmodule

[design/per_channel_median_abs_deviation_top.sv]
// ---------------------------------------------------------------------------
// Per-channel median absolute deviation
// Gathers tagged samples per channel and reports one MAD per channel.
// ---------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_bus    sink       channel, sample, sample_last
//  out_bus   source     out_channel, mad, overflowed, result_last
//  cfg_bus   sink       channels_in_use (3 bits)
//
// Loading takes one item per cycle; in_bus is not ready after the final item
// until every result of the run has been taken. A channel that holds samples
// needs two medians, each 17 passes over the store's single read port,
// settling one answer bit per pass. An empty channel skips the passes.
// Reset is synchronous; counts and flags clear, the store keeps whatever
// it held. A stalled result holds the block.
module per_channel_median_abs_deviation_top #(
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_SAMPLES  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  pcmad_in_if.sink    in_bus,
  pcmad_out_if.source out_bus,
  pcmad_cfg_if.sink   cfg_bus
);

  // The controller only sees status; every store and counter sits in the datapath.
  pcmad_pkg::cmd_t cmd;
  pcmad_pkg::sts_t sts;

  pcmad_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  pcmad_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_SAMPLES  (MAX_SAMPLES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

endmodule
